[src/gain_ar_envelope_clamp_amp_defines.svh]
// assertion helpers used by the amplifier datapath
`ifndef GAIN_AR_ENVELOPE_CLAMP_AMP_DEFINES_SVH
`define GAIN_AR_ENVELOPE_CLAMP_AMP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define GAEC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define GAEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/gaec_pkg.sv]
`default_nettype none
package gaec_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam int COEF_BITS  = 17;
   localparam int LEVEL_BITS = 17;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [LEVEL_BITS-1:0] ONE_Q16        = 17'd65536;
   localparam logic [LEVEL_BITS-1:0] SNAP_THRESHOLD = 17'd65471;

   localparam logic [COEF_BITS-1:0] GAIN_RESET    = 17'd52429;
   localparam logic [COEF_BITS-1:0] ATTACK_RESET  = 17'd148;
   localparam logic [COEF_BITS-1:0] RELEASE_RESET = 17'd30;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENV_ENABLE = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLAMP_LOW  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLAMP_HIGH = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAIN,
      ST_LEVEL,
      ST_SCALE,
      ST_FINISH
   } gaec_state_type;

   typedef struct packed {
      logic load;
      logic mul_gain;
      logic mul_level;
      logic mul_scale;
      logic emit;
   } gaec_cmd_type;

   typedef struct packed {
      logic env_on;
      logic out_busy;
   } gaec_status_type;

   // values above unity are used as unity
   function automatic logic [COEF_BITS-1:0] sat_one(input logic [COEF_BITS-1:0] v);
      sat_one = (v > ONE_Q16) ? ONE_Q16 : v;
   endfunction

endpackage
`default_nettype wire

[src/gaec_ctrl.sv]
`default_nettype none
module gaec_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  gaec_pkg::gaec_status_type status,
   output gaec_pkg::gaec_cmd_type    cmd
);
   import gaec_pkg::*;

   gaec_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_GAIN;
         end
         ST_GAIN: begin
            state_in = status.env_on ? ST_LEVEL : ST_FINISH;
         end
         ST_LEVEL: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.out_busy) state_in = req_valid ? ST_GAIN : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_GAIN: begin
            cmd.mul_gain = 1'b1;
         end
         ST_LEVEL: begin
            cmd.mul_level = 1'b1;
         end
         ST_SCALE: begin
            cmd.mul_scale = 1'b1;
         end
         ST_FINISH: begin
            // next request overlaps the hand-off to the output register
            cmd.emit  = !status.out_busy;
            req_ready = !status.out_busy;
            cmd.load  = !status.out_busy && req_valid;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

[src/gaec_dpath.sv]
`default_nettype none
`include "gain_ar_envelope_clamp_amp_defines.svh"
module gaec_dpath #(
   parameter int SAMPLE_BITS = gaec_pkg::SAMPLE_BITS_DEFAULT,
   parameter int DATA_BITS   = (SAMPLE_BITS > gaec_pkg::COEF_BITS) ? SAMPLE_BITS
                                                                    : gaec_pkg::COEF_BITS
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire signed [SAMPLE_BITS-1:0]         req_in_sample,
   input  wire                                  req_trigger,
   input  wire                                  req_block_end,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        rsp_out_sample,
   input  wire                                  csr_we,
   input  wire [gaec_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire [DATA_BITS-1:0]                  csr_data,
   input  gaec_pkg::gaec_cmd_type               cmd,
   output gaec_pkg::gaec_status_type            status
);
   import gaec_pkg::*;

   localparam int AW = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
   localparam int PW = AW + 18;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
      {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   // settings
   logic [COEF_BITS-1:0]          gain_ff, attack_ff, release_ff;
   logic                          env_enable_ff;
   logic signed [SAMPLE_BITS-1:0] clamp_low_ff, clamp_high_ff;

   // envelope state
   logic [LEVEL_BITS-1:0]         env_level_ff;
   logic                          env_active_ff;

   // working registers
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          block_end_ff;
   logic signed [SAMPLE_BITS-1:0] g_ff;
   logic signed [SAMPLE_BITS-1:0] y_ff;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_out_sample_ff;

   // shared multiplier
   logic [LEVEL_BITS-1:0]         target;
   logic signed [17:0]            diff;
   logic [COEF_BITS-1:0]          coef;
   logic signed [AW-1:0]          mul_a;
   logic signed [17:0]            mul_b;
   logic signed [PW-1:0]          prod;
   logic signed [PW-1:0]          prod_q;
   logic signed [18:0]            level_sum;
   logic [LEVEL_BITS-1:0]         level_in;
   logic signed [SAMPLE_BITS-1:0] clamped;

   always_comb begin
      target = env_active_ff ? ONE_Q16 : '0;
      diff   = $signed({1'b0, target}) - $signed({1'b0, env_level_ff});
      coef   = (env_level_ff < target) ? sat_one(attack_ff) : sat_one(release_ff);

      mul_a = AW'(sample_ff);
      mul_b = $signed({1'b0, sat_one(gain_ff)});
      if (cmd.mul_level) begin
         mul_a = AW'(diff);
         mul_b = $signed({1'b0, coef});
      end else if (cmd.mul_scale) begin
         mul_a = AW'(g_ff);
         mul_b = $signed({1'b0, env_level_ff});
      end
      prod   = PW'(mul_a) * PW'(mul_b);
      prod_q = prod >>> 16;

      level_sum = $signed({2'b00, env_level_ff}) + 19'($signed(prod_q[17:0]));
      if (level_sum < 0) begin
         level_in = '0;
      end else if (level_sum > $signed({2'b00, ONE_Q16})) begin
         level_in = ONE_Q16;
      end else begin
         level_in = level_sum[LEVEL_BITS-1:0];
      end

      // low bound first, high bound wins when crossed
      clamped = y_ff;
      if (clamped < clamp_low_ff)  clamped = clamp_low_ff;
      if (clamped > clamp_high_ff) clamped = clamp_high_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff    <= req_in_sample;
         block_end_ff <= req_block_end;
      end
      if (cmd.mul_gain) g_ff <= prod_q[SAMPLE_BITS-1:0];
      if (cmd.mul_scale) begin
         y_ff <= prod_q[SAMPLE_BITS-1:0];
      end else if (cmd.mul_gain && !env_enable_ff) begin
         y_ff <= prod_q[SAMPLE_BITS-1:0];
      end
      if (cmd.emit) rsp_out_sample_ff <= clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= GAIN_RESET;
         attack_ff     <= ATTACK_RESET;
         release_ff    <= RELEASE_RESET;
         env_enable_ff <= 1'b0;
         clamp_low_ff  <= '0;
         clamp_high_ff <= SAMPLE_MAX;
         env_level_ff  <= '0;
         env_active_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load && req_trigger) env_active_ff <= 1'b1;
         if (cmd.mul_level) env_level_ff <= level_in;
         // end of block snap once the level is near unity
         if (cmd.mul_scale && block_end_ff && env_active_ff &&
             env_level_ff >= SNAP_THRESHOLD) begin
            env_level_ff  <= ONE_Q16;
            env_active_ff <= 1'b0;
         end

         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            unique case (csr_index)
               CSR_GAIN:       gain_ff    <= csr_data[COEF_BITS-1:0];
               CSR_ATTACK:     attack_ff  <= csr_data[COEF_BITS-1:0];
               CSR_RELEASE:    release_ff <= csr_data[COEF_BITS-1:0];
               CSR_ENV_ENABLE: begin
                  env_enable_ff <= csr_data[0];
                  env_level_ff  <= '0;
                  env_active_ff <= 1'b0;
               end
               CSR_CLAMP_LOW:  clamp_low_ff  <= $signed(csr_data[SAMPLE_BITS-1:0]);
               CSR_CLAMP_HIGH: clamp_high_ff <= $signed(csr_data[SAMPLE_BITS-1:0]);
               default: begin
               end
            endcase
         end
      end
   end

   assign status.env_on   = env_enable_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_sample  = rsp_out_sample_ff;

   `GAEC_ASSERT_SAME(a_level_range, clock, reset, 1'b1, env_level_ff <= ONE_Q16, "envelope level above unity")
   `GAEC_ASSERT_SAME(a_emit_not_stalled, clock, reset, cmd.emit, !(rsp_valid_ff && !rsp_ready), "result overwrites a stalled one")
   `GAEC_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid_ff, "emitted result not presented")

endmodule
`default_nettype wire

[src/gain_ar_envelope_clamp_amp.sv]
// Gain stage with attack/release envelope and output clamp.
// Request channel (req_valid/req_ready): one signed audio sample with a
// trigger flag and a block-end flag. Response channel (rsp_valid/rsp_ready):
// one clamped sample per request, in order.
// Settings are written through csr_we/csr_index/csr_data, one register per
// cycle; the user must write them only while no request is in flight, which the block leaves unchecked.
// One shared 18-bit by max(sample width, 18)-bit multiplier does all products: gain, then
// the envelope step and the envelope scale when the envelope is enabled.
// Each request passes through the gain pass, then, with the envelope on, the
// envelope step and scale passes, and is registered into the output register
// at the finish state; the next request is taken only once it reaches finish.
// The response is held in an output register; the next request is taken and
// processed while it waits, and the block only stalls at the hand-off.
// Reset (synchronous, active high) restores the default settings, clears the
// envelope level and active flag and drops rsp_valid.
`default_nettype none
module gain_ar_envelope_clamp_amp #(
   parameter int SAMPLE_BITS = gaec_pkg::SAMPLE_BITS_DEFAULT,
   parameter int DATA_BITS   = (SAMPLE_BITS > gaec_pkg::COEF_BITS) ? SAMPLE_BITS
                                                                    : gaec_pkg::COEF_BITS
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire signed [SAMPLE_BITS-1:0]       req_in_sample,
   input  wire                                req_trigger,
   input  wire                                req_block_end,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_out_sample,
   input  wire                                csr_we,
   input  wire [gaec_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire [DATA_BITS-1:0]                csr_data
);
   import gaec_pkg::*;

   gaec_cmd_type    cmd;
   gaec_status_type status;

   gaec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gaec_dpath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .DATA_BITS   (DATA_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_in_sample  (req_in_sample),
      .req_trigger    (req_trigger),
      .req_block_end  (req_block_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sample (rsp_out_sample),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .status         (status)
   );

endmodule
`default_nettype wire

[dv/tb_gain_ar_envelope_clamp_amp.sv]
`default_nettype none
module tb_gain_ar_envelope_clamp_amp;
   import gaec_pkg::*;

   localparam int SW = SAMPLE_BITS_DEFAULT;
   localparam int DW = (SW > COEF_BITS) ? SW : COEF_BITS;
   localparam longint UNITY_Q16 = longint'(ONE_Q16);
   localparam longint SNAP_LEVEL = longint'(SNAP_THRESHOLD);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 3'd7;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_HOLD = 300;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [SW-1:0]          req_in_sample;
   logic                          req_trigger;
   logic                          req_block_end;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [SW-1:0]          rsp_out_sample;
   logic                          csr_we;
   logic [CSR_INDEX_BITS-1:0]     csr_index;
   logic [DW-1:0]                 csr_data;

   // predictor copy of settings and envelope state
   longint gain_q;
   longint attack_q;
   longint release_q;
   bit     env_en;
   longint clamp_lo;
   longint clamp_hi;
   longint env_level_q;
   bit     env_armed;

   logic signed [SW-1:0] expected_samples[$];
   bit idle_on;
   int hold_cycles;
   int stall_left;
   int mismatches;
   int quiet_cycles;

   gain_ar_envelope_clamp_amp i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_sample  (req_in_sample),
      .req_trigger    (req_trigger),
      .req_block_end  (req_block_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sample (rsp_out_sample),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic longint limit_unity(input longint v);
      return (v > UNITY_Q16) ? UNITY_Q16 : v;
   endfunction

   function automatic void apply_setting(input logic [CSR_INDEX_BITS-1:0] index,
                                         input logic [DW-1:0] data);
      case (index)
         CSR_GAIN: begin
            gain_q = longint'(data[COEF_BITS-1:0]);
         end
         CSR_ATTACK: begin
            attack_q = longint'(data[COEF_BITS-1:0]);
         end
         CSR_RELEASE: begin
            release_q = longint'(data[COEF_BITS-1:0]);
         end
         CSR_ENV_ENABLE: begin
            env_en = data[0];
            env_level_q = 0;
            env_armed = 1'b0;
         end
         CSR_CLAMP_LOW: begin
            clamp_lo = longint'($signed(data[SW-1:0]));
         end
         CSR_CLAMP_HIGH: begin
            clamp_hi = longint'($signed(data[SW-1:0]));
         end
         default: begin
         end
      endcase
   endfunction

   // gain, envelope step and scale, clamp; products floor via arithmetic shift
   function automatic logic signed [SW-1:0] predict_out_sample(input logic signed [SW-1:0] s,
                                                               input bit trig,
                                                               input bit last);
      longint y;
      longint goal;
      longint coef;
      if (trig) begin
         env_armed = 1'b1;
      end
      y = (longint'(s) * limit_unity(gain_q)) >>> 16;
      if (env_en) begin
         goal = env_armed ? UNITY_Q16 : 0;
         coef = (env_level_q < goal) ? limit_unity(attack_q) : limit_unity(release_q);
         env_level_q = env_level_q + ((coef * (goal - env_level_q)) >>> 16);
         if (env_level_q < 0) begin
            env_level_q = 0;
         end
         if (env_level_q > UNITY_Q16) begin
            env_level_q = UNITY_Q16;
         end
         y = (y * env_level_q) >>> 16;
      end
      if (y < clamp_lo) begin
         y = clamp_lo;
      end
      if (y > clamp_hi) begin
         y = clamp_hi;
      end
      // end of block: near-full level snaps to unity and release starts
      if (last && env_en && env_armed && env_level_q >= SNAP_LEVEL) begin
         env_level_q = UNITY_Q16;
         env_armed = 1'b0;
      end
      return y[SW-1:0];
   endfunction

   function automatic logic signed [SW-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return '0;
         3: return '1;
         default: return SW'($urandom);
      endcase
   endfunction

   function automatic logic [DW-1:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return DW'(UNITY_Q16);
         2: return DW'($urandom_range(65537, 131071));
         3: return DW'($urandom_range(1, 1023));
         default: return DW'($urandom_range(1024, 65535));
      endcase
   endfunction

   task automatic send_sample(input logic signed [SW-1:0] s, input bit trig, input bit last);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_sample <= s;
      req_trigger <= trig;
      req_block_end <= last;
      do @(posedge clock); while (!req_ready);
      expected_samples.push_back(predict_out_sample(s, trig, last));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index, input logic [DW-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      apply_setting(index, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_clamps(input logic signed [SW-1:0] lo, input logic signed [SW-1:0] hi);
      write_reg(CSR_CLAMP_LOW, {1'($urandom_range(0, 1)), lo});
      write_reg(CSR_CLAMP_HIGH, {1'($urandom_range(0, 1)), hi});
   endtask

   task automatic run_default_settings_test();
      send_sample(16'sh7fff, 1'b0, 1'b0);
      send_sample(16'sh8000, 1'b0, 1'b0);
      send_sample(-16'sd1, 1'b1, 1'b1);
      send_sample(16'sd1, 1'b0, 1'b1);
      send_sample(16'sd0, 1'b0, 1'b0);
      wait_idle();
   endtask

   task automatic run_gain_clamp_test();
      write_reg(CSR_GAIN, DW'(UNITY_Q16));
      write_clamps(16'sh8000, 16'sh7fff);
      send_sample(16'sh7fff, 1'b0, 1'b0);
      send_sample(16'sh8000, 1'b0, 1'b0);
      wait_idle();
      // above unity is used as unity
      write_reg(CSR_GAIN, 17'h1ffff);
      send_sample(16'sh8000, 1'b0, 1'b1);
      send_sample(16'sd12345, 1'b0, 1'b0);
      wait_idle();
      write_reg(CSR_GAIN, '0);
      send_sample(16'sh7fff, 1'b0, 1'b0);
      wait_idle();
      // crossed bounds: high bound wins
      write_reg(CSR_GAIN, DW'(UNITY_Q16));
      write_clamps(16'sd1000, -16'sd1000);
      send_sample(16'sh8000, 1'b0, 1'b0);
      send_sample(16'sh7fff, 1'b0, 1'b0);
      wait_idle();
      write_reg(CSR_SPARE, DW'($urandom));
      send_sample(16'sd5, 1'b0, 1'b0);
      wait_idle();
   endtask

   task automatic run_envelope_test();
      write_clamps(16'sh8000, 16'sh7fff);
      write_reg(CSR_ATTACK, DW'(UNITY_Q16));
      write_reg(CSR_RELEASE, DW'(UNITY_Q16));
      write_reg(CSR_ENV_ENABLE, DW'(1));
      send_sample(16'sd20000, 1'b0, 1'b0);
      send_sample(16'sd20000, 1'b1, 1'b0);
      send_sample(-16'sd20000, 1'b0, 1'b1);
      send_sample(16'sd20000, 1'b0, 1'b0);
      wait_idle();
      write_reg(CSR_ATTACK, 17'h1ffff);
      send_sample(16'sh7fff, 1'b1, 1'b1);
      wait_idle();
      // trigger with envelope off arms it, but no end check
      write_reg(CSR_ENV_ENABLE, '0);
      send_sample(16'sd100, 1'b1, 1'b1);
      wait_idle();
      write_reg(CSR_ATTACK, DW'(32768));
      write_reg(CSR_RELEASE, DW'(16384));
      write_reg(CSR_ENV_ENABLE, DW'(1));
      send_sample(16'sd30000, 1'b1, 1'b0);
      send_sample(16'sd30000, 1'b0, 1'b1);
      send_sample(-16'sd30000, 1'b0, 1'b0);
      wait_idle();
   endtask

   task automatic run_stall_test();
      idle_on = 1'b0;
      hold_cycles = LONG_HOLD;
      for (int i = 0; i < 24; i++) begin
         send_sample(pick_sample(), ($urandom_range(0, 7) == 0), ($urandom_range(0, 7) == 0));
      end
      wait_idle();
      idle_on = 1'b1;
   endtask

   task automatic randomize_settings();
      logic [DW-1:0] gain_val;
      logic [DW-1:0] en_val;
      logic signed [SW-1:0] lo;
      logic signed [SW-1:0] hi;
      case ($urandom_range(0, 5))
         0: gain_val = '0;
         1: gain_val = DW'(UNITY_Q16);
         2: gain_val = DW'($urandom_range(65537, 131071));
         default: gain_val = DW'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 3))
         0: begin
            lo = 16'sh8000;
            hi = 16'sh7fff;
         end
         1: begin
            lo = SW'($urandom);
            hi = SW'($urandom);
         end
         2: begin
            lo = -SW'($urandom_range(0, 32768));
            hi = SW'($urandom_range(0, 32767));
         end
         default: begin
            lo = SW'($urandom_range(0, 32767));
            hi = -SW'($urandom_range(1, 32768));
         end
      endcase
      en_val = DW'($urandom);
      en_val[0] = ($urandom_range(0, 3) != 0);
      write_reg(CSR_GAIN, gain_val);
      write_reg(CSR_ATTACK, pick_coef());
      write_reg(CSR_RELEASE, pick_coef());
      write_clamps(lo, hi);
      write_reg(CSR_ENV_ENABLE, en_val);
   endtask

   task automatic run_random_test();
      int sent;
      int blk_len;
      for (int sec = 0; sec < 14; sec++) begin
         if (sec == 13) begin
            idle_on = 1'b0;
         end
         randomize_settings();
         sent = 0;
         while (sent < 100) begin
            if ($urandom_range(0, 4) != 0) begin
               // triggered block of samples ending with a block end
               blk_len = $urandom_range(2, 24);
               for (int i = 0; i < blk_len; i++) begin
                  send_sample(pick_sample(), (i == 0) || ($urandom_range(0, 15) == 0),
                              (i == blk_len - 1));
                  sent++;
               end
            end else begin
               send_sample(pick_sample(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
         wait_idle();
      end
   endtask

   // result side: check against oldest expectation, then decide ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected out_sample %0d with nothing pending", rsp_out_sample);
            end
         end else begin
            if (rsp_out_sample !== expected_samples[0]) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("out_sample mismatch: expected %0d, got %0d",
                           expected_samples[0], rsp_out_sample);
               end
            end
            void'(expected_samples.pop_front());
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("gain_ar_envelope_clamp_amp test failed");
               $finish;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_sample = '0;
      req_trigger = 1'b0;
      req_block_end = 1'b0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_on = 1'b1;
      hold_cycles = 0;
      stall_left = 0;
      mismatches = 0;
      quiet_cycles = 0;
      gain_q = longint'(GAIN_RESET);
      attack_q = longint'(ATTACK_RESET);
      release_q = longint'(RELEASE_RESET);
      env_en = 1'b0;
      clamp_lo = 0;
      clamp_hi = 32767;
      env_level_q = 0;
      env_armed = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_default_settings_test();
      run_gain_clamp_test();
      run_envelope_test();
      run_stall_test();
      run_random_test();
      wait_idle();
      if (mismatches == 0) begin
         $display("gain_ar_envelope_clamp_amp test passed");
      end else begin
         $display("gain_ar_envelope_clamp_amp test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
